// ----- hdl/tsq_pkg.sv -----
// Package for the tone sequencer: payload structs, opcodes, FSM states
// and the timing constants. No dependencies.
`timescale 1ns / 1ps

package tsq_pkg;

  localparam int unsigned CLOCK_HZ  = 8000000;
  localparam int unsigned TICK_MS   = 10;
  localparam int unsigned DEAD_TIME = 2;

  // Timer input clock is the system clock divided by eight.
  localparam int unsigned DIVIDEND = CLOCK_HZ / 8;
  localparam int unsigned DIV_W    = $clog2(DIVIDEND + 1);
  localparam int unsigned CNT_W    = $clog2(DIV_W);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PLAY  = 2'd1,
    OP_QUEUE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] tone_hz;
    logic [15:0] duration_ms;
  } tsq_in_t;

  typedef struct packed {
    logic        tone_on;
    logic        reprogram;
    logic [15:0] period_count;
    logic [15:0] compare_low;
    logic [15:0] compare_high;
  } tsq_out_t;

endpackage

// ----- hdl/tone_sequencer_with_queue_core.sv -----
// Buzzer tone sequencer with one playing slot and a one-deep queue.
// Depends on tsq_pkg for payload structs, opcodes, states and constants.
`timescale 1ns / 1ps

// Usage:
// Each transfer on the input channel (in_valid/in_ready, payload in_data)
// carries one command: a tick, a play-now request or a queue request.
// Every command produces exactly one result transfer on the output
// channel (out_valid/out_ready, payload out_data) showing the tone timer
// after the command.
// Commands that do not reload the timer go from acceptance straight to
// the emit stage and then to the output register. Commands that start a
// nonzero frequency first run a radix-2 restoring divider that retires
// one quotient bit per cycle, then the finish stage and the emit stage.
// Only one command is in flight at a time; the next is taken once the
// result has been placed in the output register.
// Reset (rst_n low, synchronous) stops the timer, empties the queue and
// clears the countdown. If the receiver stalls, the result stays in the
// output register and the block still accepts one new command; that
// command waits in the emit stage until the output register is free.
module tone_sequencer_with_queue_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tsq_pkg::tsq_in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tsq_pkg::tsq_out_t out_data
);
  import tsq_pkg::*;

  state_t      state_r, state_nxt;
  logic [15:0] rem_ms_r, rem_ms_nxt;
  logic [15:0] playing_hz_r, playing_hz_nxt;
  logic [15:0] queued_ms_r, queued_ms_nxt;
  logic [15:0] queued_hz_r, queued_hz_nxt;
  logic        tmr_run_r, tmr_run_nxt;
  logic [15:0] tmr_period_r, tmr_period_nxt;
  logic [15:0] tmr_low_r, tmr_low_nxt;
  logic [15:0] tmr_high_r, tmr_high_nxt;
  logic        reprog_r, reprog_nxt;

  // Serial divider: partial remainder, quotient/dividend shift register
  // and bit counter.
  logic [15:0]      div_rem_r, div_rem_nxt;
  logic [DIV_W-1:0] div_quo_r, div_quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  tsq_out_t out_data_r, out_data_nxt;
  logic     out_valid_r, out_valid_nxt;

  logic        in_fire;
  logic        prog_req;
  logic [15:0] prog_hz;
  logic [16:0] div_shift;
  logic [17:0] div_diff;
  logic [15:0] period_sat;
  logic [14:0] half;
  logic [16:0] high_sum;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // One divider step: shift in the next dividend bit and try a subtract.
  assign div_shift = {div_rem_r, div_quo_r[DIV_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, playing_hz_r};

  // Compare values from the saturated period.
  assign period_sat = (|div_quo_r[DIV_W-1:16]) ? 16'hFFFF : div_quo_r[15:0];
  assign half       = period_sat[15:1];
  assign high_sum   = {1'b0, period_sat} - {2'b00, half} + 17'(DEAD_TIME);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rem_ms_r     <= '0;
      playing_hz_r <= '0;
      queued_ms_r  <= '0;
      queued_hz_r  <= '0;
      tmr_run_r    <= 1'b0;
      tmr_period_r <= '0;
      tmr_low_r    <= '0;
      tmr_high_r   <= '0;
      reprog_r     <= 1'b0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rem_ms_r     <= rem_ms_nxt;
      playing_hz_r <= playing_hz_nxt;
      queued_ms_r  <= queued_ms_nxt;
      queued_hz_r  <= queued_hz_nxt;
      tmr_run_r    <= tmr_run_nxt;
      tmr_period_r <= tmr_period_nxt;
      tmr_low_r    <= tmr_low_nxt;
      tmr_high_r   <= tmr_high_nxt;
      reprog_r     <= reprog_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    div_rem_r  <= div_rem_nxt;
    div_quo_r  <= div_quo_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    rem_ms_nxt     = rem_ms_r;
    playing_hz_nxt = playing_hz_r;
    queued_ms_nxt  = queued_ms_r;
    queued_hz_nxt  = queued_hz_r;
    tmr_run_nxt    = tmr_run_r;
    tmr_period_nxt = tmr_period_r;
    tmr_low_nxt    = tmr_low_r;
    tmr_high_nxt   = tmr_high_r;
    reprog_nxt     = reprog_r;
    div_rem_nxt    = div_rem_r;
    div_quo_nxt    = div_quo_r;
    cnt_nxt        = cnt_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    prog_req       = 1'b0;
    prog_hz        = '0;

    // The receiver takes the held result.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.opcode)
            OP_TICK: begin
              if (rem_ms_r != '0) begin
                // Countdown; running below one tick clamps to zero.
                if (rem_ms_r > 16'(TICK_MS)) begin
                  rem_ms_nxt = rem_ms_r - 16'(TICK_MS);
                end else begin
                  rem_ms_nxt = '0;
                end
              end else if (queued_ms_r != '0) begin
                // Expired: start the queued tone.
                if (playing_hz_r != queued_hz_r) begin
                  prog_req = 1'b1;
                  prog_hz  = queued_hz_r;
                end
                rem_ms_nxt    = queued_ms_r;
                queued_ms_nxt = '0;
              end else begin
                // Expired with an empty queue: stop the timer every time.
                prog_req = 1'b1;
                prog_hz  = '0;
              end
            end
            OP_PLAY: begin
              if (playing_hz_r != in_data.tone_hz) begin
                prog_req = 1'b1;
                prog_hz  = in_data.tone_hz;
              end
              rem_ms_nxt    = in_data.duration_ms;
              queued_ms_nxt = '0;
            end
            OP_QUEUE: begin
              queued_hz_nxt = in_data.tone_hz;
              queued_ms_nxt = in_data.duration_ms;
            end
            default: begin
            end
          endcase

          reprog_nxt = prog_req;
          state_nxt  = ST_EMIT;
          if (prog_req) begin
            playing_hz_nxt = prog_hz;
            if (prog_hz == '0) begin
              tmr_run_nxt    = 1'b0;
              tmr_period_nxt = '0;
              tmr_low_nxt    = '0;
              tmr_high_nxt   = '0;
            end else begin
              // Load the dividend and start the serial division.
              tmr_run_nxt = 1'b1;
              div_rem_nxt = '0;
              div_quo_nxt = DIV_W'(DIVIDEND);
              cnt_nxt     = CNT_W'(DIV_W - 1);
              state_nxt   = ST_DIV;
            end
          end
        end
      end

      ST_DIV: begin
        if (!div_diff[17]) begin
          div_rem_nxt = div_diff[15:0];
          div_quo_nxt = {div_quo_r[DIV_W-2:0], 1'b1};
        end else begin
          div_rem_nxt = div_shift[15:0];
          div_quo_nxt = {div_quo_r[DIV_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        tmr_period_nxt = period_sat;
        tmr_low_nxt    = (half > 15'(DEAD_TIME)) ? 16'(half - 15'(DEAD_TIME)) : '0;
        tmr_high_nxt   = high_sum[16] ? 16'hFFFF : high_sum[15:0];
        state_nxt      = ST_EMIT;
      end

      ST_EMIT: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_r || out_ready) begin
          out_data_nxt.tone_on      = tmr_run_r;
          out_data_nxt.reprogram    = reprog_r;
          out_data_nxt.period_count = tmr_period_r;
          out_data_nxt.compare_low  = tmr_low_r;
          out_data_nxt.compare_high = tmr_high_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The run bit follows the remembered frequency.
  a_run_matches_hz: assert property (@(posedge clk) disable iff (!rst_n)
    tmr_run_r == (playing_hz_r != '0))
    else $error("timer run bit disagrees with playing frequency");

  // A stopped timer shows all-zero values.
  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !tmr_run_r |-> (tmr_period_r == '0 && tmr_low_r == '0 && tmr_high_r == '0))
    else $error("stopped timer holds nonzero values");

  // A running timer has a nonzero period once the division has finished.
  a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (tmr_run_r && state_r == ST_IDLE) |-> tmr_period_r != '0)
    else $error("running timer with zero period");

  // An accepted command keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("new command accepted before the previous one finished");

endmodule
